/* design/olist_pkg.sv */
package olist_pkg;

    // command codes
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;
    localparam logic [1:0] KIND_DELETE = 2'd2;
    localparam logic [1:0] KIND_QUERY  = 2'd3;

    // widths that cover the largest supported list
    localparam int IDX_W = 8;
    localparam int CNT_W = 9;

    typedef struct packed {
        logic [1:0]         kind;
        logic [4:0]         position;
        logic signed [31:0] word;
    } t_olist_cmd;

    typedef struct packed {
        logic       accepted;
        logic       found;
        logic [3:0] first_match_res;
        logic [4:0] match_count;
        logic [4:0] length;
    } t_olist_res;

    // broadcast to every cell in the cycle a command is taken
    typedef struct packed {
        logic             shift_up;
        logic             shift_dn;
        logic [IDX_W-1:0] pos;
        logic [31:0]      word;
    } t_olist_ctrl;

    // search token handed from cell to cell
    typedef struct packed {
        logic             tok;
        logic             found;
        logic [IDX_W-1:0] first;
        logic [CNT_W-1:0] cnt;
    } t_olist_scan;

endpackage

/* design/olist_cell.sv */
module olist_cell
    import olist_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_olist_ctrl i_ctrl,
    input  logic [31:0] i_prev_word,
    input  logic [31:0] i_next_word,
    input  logic [31:0] i_key,
    input  logic [CNT_W-1:0] i_fill,
    input  t_olist_scan i_scan,
    output logic [31:0] o_word,
    output t_olist_scan o_scan
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [31:0] r_word;
    logic [31:0] n_word;
    t_olist_scan r_scan;
    t_olist_scan n_scan;
    logic        hit;

    always_comb begin
        n_word = r_word;
        if (i_ctrl.shift_up) begin
            if (MY_IDX > i_ctrl.pos) begin
                n_word = i_prev_word;
            end else if (MY_IDX == i_ctrl.pos) begin
                n_word = i_ctrl.word;
            end
        end else if (i_ctrl.shift_dn) begin
            if (MY_IDX >= i_ctrl.pos) begin
                n_word = i_next_word;
            end
        end
    end

    // only entries below the fill count take part in a search
    assign hit = (CNT_W'(IDX) < i_fill) && (r_word == i_key);

    always_comb begin
        n_scan       = i_scan;
        n_scan.cnt   = i_scan.cnt + CNT_W'(hit);
        n_scan.found = i_scan.found | hit;
        if (hit && !i_scan.found) begin
            n_scan.first = MY_IDX;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_scan <= n_scan;
        if (!i_rst_n) begin
            r_scan.tok <= 1'b0;
        end
    end

    assign o_word = r_word;
    assign o_scan = r_scan;

endmodule

/* design/ordered_list_insert_delete_search.sv */
// Ordered list of up to CAPACITY signed 32-bit words. A command is taken when
// start is high and busy is low. An accepted insert, append or delete shifts
// the entries from its position upward at once and delivers its result on the
// next cycle. A query sends a search token down the row of cells, one cell
// per cycle, and keeps busy high until its result appears. Each result
// is shown for one cycle with o_strobe; the receiver must take it then.
module ordered_list_insert_delete_search
    import olist_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  t_olist_cmd i_cmd,
    output logic       busy,
    output logic       o_strobe,
    output t_olist_res o_res
);

    localparam int FW = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_V = CNT_W'(CAPACITY);

    logic [FW-1:0]    r_fill;
    logic [FW-1:0]    n_fill;
    logic             r_busy;
    logic             r_seed_tok;
    logic [31:0]      r_key;
    logic             r_strobe;
    t_olist_res       r_res;
    logic             take;
    logic [CNT_W-1:0] fill_w;
    logic [CNT_W-1:0] pos_w;
    logic             ok;
    t_olist_ctrl      ctrl;
    t_olist_scan      scan [CAPACITY+1];
    logic [31:0]      words [CAPACITY];

    assign take   = start && !r_busy;
    assign fill_w = CNT_W'(r_fill);
    assign pos_w  = CNT_W'(i_cmd.position);

    always_comb begin
        ok            = 1'b0;
        ctrl.shift_up = 1'b0;
        ctrl.shift_dn = 1'b0;
        ctrl.pos      = pos_w[IDX_W-1:0];
        ctrl.word     = i_cmd.word;
        n_fill        = r_fill;
        unique case (i_cmd.kind)
            KIND_INSERT: begin
                ok            = (pos_w <= fill_w) && (fill_w < CAP_V);
                ctrl.shift_up = take && ok;
            end
            KIND_APPEND: begin
                ok            = fill_w < CAP_V;
                ctrl.shift_up = take && ok;
                ctrl.pos      = fill_w[IDX_W-1:0];
            end
            KIND_DELETE: begin
                ok            = pos_w < fill_w;
                ctrl.shift_dn = take && ok;
            end
            KIND_QUERY: begin
                ok = 1'b1;
            end
            default: ok = 1'b0;
        endcase
        if (ctrl.shift_up) begin
            n_fill = r_fill + FW'(1);
        end else if (ctrl.shift_dn) begin
            n_fill = r_fill - FW'(1);
        end
    end

    assign scan[0] = '{tok: r_seed_tok, found: 1'b0, first: '0, cnt: '0};

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        olist_cell #(
            .IDX(g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (ctrl),
            .i_prev_word((g == 0) ? i_cmd.word : words[(g == 0) ? 0 : g - 1]),
            .i_next_word(words[(g == CAPACITY - 1) ? g : g + 1]),
            .i_key      (r_key),
            .i_fill     (fill_w),
            .i_scan     (scan[g]),
            .o_word     (words[g]),
            .o_scan     (scan[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        r_strobe <= 1'b0;
        if (take) begin
            r_fill <= n_fill;
            r_key  <= i_cmd.word;
            if (i_cmd.kind == KIND_QUERY) begin
                r_busy <= 1'b1;
            end else begin
                r_strobe <= 1'b1;
            end
            r_res.accepted        <= ok;
            r_res.found           <= 1'b0;
            r_res.first_match_res <= '0;
            r_res.match_count     <= '0;
            r_res.length          <= 5'(n_fill);
        end
        // token is entering the last cell, result shows next cycle
        if (scan[CAPACITY-1].tok) begin
            r_busy <= 1'b0;
        end
        r_seed_tok <= take && (i_cmd.kind == KIND_QUERY);
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_busy     <= 1'b0;
            r_seed_tok <= 1'b0;
            r_strobe   <= 1'b0;
        end
    end

    assign busy     = r_busy;
    assign o_strobe = r_strobe || scan[CAPACITY].tok;

    always_comb begin
        o_res = r_res;
        if (scan[CAPACITY].tok) begin
            o_res.accepted        = 1'b1;
            o_res.found           = scan[CAPACITY].found;
            o_res.first_match_res = scan[CAPACITY].first[3:0];
            o_res.match_count     = scan[CAPACITY].cnt[4:0];
            o_res.length          = 5'(r_fill);
        end
    end

endmodule

/* design/olist_chk.sv */
module olist_chk
    import olist_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  t_olist_cmd i_cmd,
    input  logic       busy,
    input  logic       o_strobe,
    input  t_olist_res o_res
);

    // list updates answer on the very next cycle
    a_update_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_cmd.kind != KIND_QUERY) |=> o_strobe)
        else $error("no result after list update transfer");

    // a search holds off new commands
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_cmd.kind == KIND_QUERY) |=> busy && !o_strobe)
        else $error("query transfer did not raise busy");

    a_miss_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_res.found |-> (o_res.first_match_res == 4'd0)
            && (o_res.match_count == 5'd0))
        else $error("miss reports a position or count");

    a_refused_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_res.accepted |-> !o_res.found)
        else $error("refused command reports a match");

endmodule

bind ordered_list_insert_delete_search olist_chk u_olist_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .i_cmd   (i_cmd),
    .busy    (busy),
    .o_strobe(o_strobe),
    .o_res   (o_res)
);

/* tb/sv/ordered_list_insert_delete_search_tb.sv */
module ordered_list_insert_delete_search_tb;
    import olist_pkg::*;

    localparam int CAP = 16;
    localparam int N_RANDOM = 1800;
    localparam int STALL_LIMIT = 2000;

    typedef struct {
        t_olist_cmd cmd;
        bit         drain;
    } t_pending;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    t_olist_cmd i_cmd = '0;
    logic       busy;
    logic       o_strobe;
    t_olist_res o_res;

    ordered_list_insert_delete_search #(.CAPACITY(CAP)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_cmd   (i_cmd),
        .busy    (busy),
        .o_strobe(o_strobe),
        .o_res   (o_res)
    );

    always #2 i_clk = ~i_clk;

    // commands waiting to be driven and results still owed by the block
    t_pending   cmd_q[$];
    t_olist_res owed_q[$];

    // shadow copy of the list
    logic signed [31:0] shadow[CAP];
    int                 shadow_len = 0;

    int  sent_count = 0;
    int  recv_count = 0;
    int  mismatches = 0;
    int  gap_left = 0;
    bit  no_idle = 1'b0;
    int  kind_cnt[4] = '{0, 0, 0, 0};
    int  refused_cnt = 0;
    int  hit_cnt = 0;
    int  full_cnt = 0;
    int  empty_cnt = 0;

    // list length as seen by the stimulus generator
    int  gen_len = 0;

    logic signed [31:0] pool[8] = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, -32'sd1,
                                    32'sd1, 32'sh5a5a_5a5a, -32'sd2, 32'sh1234_5678};

    function automatic t_olist_res apply_cmd(t_olist_cmd c);
        t_olist_res r;
        int         p;
        bit         put;
        int         hits;
        int         lowest;
        r = '0;
        p = c.position;
        put = 1'b0;
        hits = 0;
        lowest = 0;
        case (c.kind)
            KIND_INSERT: begin
                put = (p <= shadow_len) && (shadow_len < CAP);
            end
            KIND_APPEND: begin
                p = shadow_len;
                put = shadow_len < CAP;
            end
            KIND_DELETE: begin
                if (p < shadow_len) begin
                    for (int i = p; i + 1 < shadow_len; i++)
                        shadow[i] = shadow[i + 1];
                    shadow_len--;
                    r.accepted = 1'b1;
                end
            end
            default: begin
                r.accepted = 1'b1;
                for (int i = 0; i < shadow_len; i++) begin
                    if (shadow[i] == c.word) begin
                        if (hits == 0)
                            lowest = i;
                        hits++;
                    end
                end
                r.found = hits != 0;
                r.first_match_res = lowest[3:0];
                r.match_count = hits[4:0];
            end
        endcase
        if (put) begin
            for (int i = shadow_len; i > p; i--)
                shadow[i] = shadow[i - 1];
            shadow[p] = c.word;
            shadow_len++;
            r.accepted = 1'b1;
        end
        r.length = shadow_len[4:0];
        return r;
    endfunction

    task automatic add_cmd(logic [1:0] kind, int pos, logic signed [31:0] word, bit drain);
        t_pending it;
        it.cmd.kind = kind;
        it.cmd.position = pos[4:0];
        it.cmd.word = word;
        it.drain = drain;
        cmd_q.push_back(it);
        case (kind)
            KIND_INSERT: if (pos <= gen_len && gen_len < CAP) gen_len++;
            KIND_APPEND: if (gen_len < CAP) gen_len++;
            KIND_DELETE: if (pos < gen_len) gen_len--;
            default: ;
        endcase
    endtask

    function automatic logic signed [31:0] pick_word();
        if ($urandom_range(0, 1) == 0)
            return pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic check_field(string fname, logic [31:0] want_v, logic [31:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s expected %0d, got %0d", $time, fname, want_v, got_v);
            mismatches++;
        end
    endtask

    // driver: holds a command until the block takes it, then idles or moves on
    always @(posedge i_clk) begin : drive_cmds
        bit         taken;
        t_olist_res r;
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_left = 0;
        end else begin
            taken = start && !busy;
            if (taken) begin
                r = apply_cmd(i_cmd);
                owed_q.push_back(r);
                kind_cnt[i_cmd.kind]++;
                if (!r.accepted) refused_cnt++;
                if (r.found) hit_cnt++;
                if (r.length == CAP) full_cnt++;
                if (r.length == 0) empty_cnt++;
                sent_count <= sent_count + 1;
                cmd_q.delete(0);
                if ($urandom_range(0, 99) == 0)
                    no_idle = !no_idle;
                gap_left = pick_gap();
            end
            if (taken || !start) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (cmd_q.size() != 0 &&
                             (!cmd_q[0].drain || sent_count + taken == recv_count)) begin
                    start <= 1'b1;
                    i_cmd <= cmd_q[0].cmd;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: every strobe is one result transfer
    always @(posedge i_clk) begin : check_results
        t_olist_res want;
        if (i_rst_n && o_strobe) begin
            if (owed_q.size() == 0) begin
                $display("%0t: result with none expected, got %p", $time, o_res);
                mismatches++;
            end else begin
                want = owed_q.pop_front();
                check_field("accepted", want.accepted, o_res.accepted);
                check_field("found", want.found, o_res.found);
                check_field("first_match_res", want.first_match_res, o_res.first_match_res);
                check_field("match_count", want.match_count, o_res.match_count);
                check_field("length", want.length, o_res.length);
                recv_count <= recv_count + 1;
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        int idle_cycles;
        if (!i_rst_n) begin
            idle_cycles = 0;
        end else if ((start && !busy) || o_strobe) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: timeout, no transfer for %0d cycles", $time, idle_cycles);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        int grow_pct;
        int total;
        int r;
        int p;

        // directed: empty list, bounds, extremes, full list, duplicates
        add_cmd(KIND_QUERY, 0, 32'sh0, 1'b0);
        add_cmd(KIND_DELETE, 0, 32'sh0, 1'b0);
        add_cmd(KIND_INSERT, 1, 32'sd5, 1'b0);
        add_cmd(KIND_INSERT, 0, 32'sh7fff_ffff, 1'b0);
        add_cmd(KIND_APPEND, 16, 32'sh8000_0000, 1'b0);
        add_cmd(KIND_INSERT, 1, -32'sd1, 1'b0);
        add_cmd(KIND_QUERY, 0, -32'sd1, 1'b0);
        add_cmd(KIND_INSERT, 3, 32'sh0, 1'b0);
        for (int k = 0; k < 12; k++)
            add_cmd(KIND_APPEND, 0, (k % 4 == 0) ? -32'sd1 : 32'sh7fff_ffff - k, 1'b0);
        add_cmd(KIND_APPEND, 0, 32'sd9, 1'b0);
        add_cmd(KIND_INSERT, 16, 32'sd9, 1'b0);
        add_cmd(KIND_QUERY, 16, -32'sd1, 1'b0);
        add_cmd(KIND_DELETE, 16, 32'sh0, 1'b0);
        add_cmd(KIND_DELETE, 15, 32'sh0, 1'b0);
        add_cmd(KIND_DELETE, 0, 32'sh0, 1'b0);

        // random: phases that lean toward growing or shrinking the list
        grow_pct = 50;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 150 == 0)
                grow_pct = (n / 150 % 3 == 0) ? 75 : (n / 150 % 3 == 1) ? 25 : 50;
            r = $urandom_range(0, 99);
            if (r < 35) begin
                add_cmd(KIND_QUERY, $urandom_range(0, 16),
                        ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, 7)] : $urandom,
                        n == 0 || $urandom_range(0, 199) == 0);
            end else if ($urandom_range(0, 99) < grow_pct) begin
                if ($urandom_range(0, 2) == 0) begin
                    add_cmd(KIND_APPEND, $urandom_range(0, 16), pick_word(),
                            $urandom_range(0, 199) == 0);
                end else begin
                    p = ($urandom_range(0, 99) < 85) ? $urandom_range(0, gen_len)
                                                    : $urandom_range(0, 16);
                    add_cmd(KIND_INSERT, p, pick_word(), $urandom_range(0, 199) == 0);
                end
            end else begin
                p = ($urandom_range(0, 99) < 85 && gen_len > 0) ? $urandom_range(0, gen_len - 1)
                                                              : $urandom_range(0, 16);
                add_cmd(KIND_DELETE, p, pick_word(), $urandom_range(0, 199) == 0);
            end
        end
        total = cmd_q.size();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (sent_count != total)
            @(posedge i_clk);
        while (recv_count != sent_count)
            @(posedge i_clk);
        repeat (CAP + 8) @(posedge i_clk);

        if (owed_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, owed_q.size());
            mismatches++;
        end
        $display("ran %0d commands: %0d insert, %0d append, %0d delete, %0d query",
                 sent_count, kind_cnt[KIND_INSERT], kind_cnt[KIND_APPEND],
                 kind_cnt[KIND_DELETE], kind_cnt[KIND_QUERY]);
        $display("%0d refused, %0d queries hit, list full %0d times, empty %0d times",
                 refused_cnt, hit_cnt, full_cnt, empty_cnt);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
